// File: hw/rtl/ddwc_pkg.sv
// Shared types, constants and helper functions of the differential drive wheel command unit.
package ddwc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_W = 31;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_W-1:0] CFG_RESET = 31'd65536;

  // Pi with thirty fractional bits.
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam int PI_FRAC = 30;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WHEEL_BASE     = 2'd0,
    CFG_MAX_SPEED      = 2'd1,
    CFG_STEPS_PER_DIST = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] fwd_speed;
    logic signed [31:0] fwd_accel;
    logic signed [31:0] turn_rate;
    logic signed [31:0] travel;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] right_rate;
    logic signed [31:0] left_rate;
    logic signed [31:0] right_ramp;
    logic signed [31:0] left_ramp;
    logic signed [31:0] right_steps;
    logic signed [31:0] left_steps;
    logic               speed_limited;
    logic               zero_speed;
  } result_t;

  function automatic logic [31:0] mag32(input logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  function automatic logic [31:0] sat32(input logic ovf, input logic [31:0] mag,
                                        input logic neg);
    logic [31:0] cap;
    logic [31:0] v;
    cap = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    v = (ovf || (mag > cap)) ? cap : mag;
    return neg ? (~v + 32'd1) : v;
  endfunction

endpackage

// File: hw/rtl/ddwc_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with a side bus carried alongside.
module ddwc_divider #(
  parameter int NUM_W  = 80,
  parameter int DEN_W  = 49,
  parameter int Q_W    = 49,
  parameter int LANES  = 1,
  parameter int SIDE_W = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic [LANES-1:0][NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]             den,
  input  logic [SIDE_W-1:0]            side_in,
  output logic                         out_vld,
  output logic [LANES-1:0][Q_W-1:0]    quot,
  output logic [SIDE_W-1:0]            side_out
);

  // The caller guarantees num >> Q_W < den whenever the quotient is used.
  logic [Q_W:0]                      vld_r;
  logic [DEN_W-1:0]                  den_r  [Q_W+1];
  logic [SIDE_W-1:0]                 side_r [Q_W+1];
  logic [LANES-1:0][DEN_W-1:0]       rem_r  [Q_W+1];
  logic [LANES-1:0][Q_W-1:0]         acc_r  [Q_W+1];
  logic [LANES-1:0][DEN_W-1:0]       rem_nxt [Q_W+1];
  logic [LANES-1:0][Q_W-1:0]         acc_nxt [Q_W+1];

  always_comb begin
    logic [DEN_W:0] t;
    logic [DEN_W:0] diff;
    for (int s = 0; s <= Q_W; s++) begin
      rem_nxt[s] = '0;
      acc_nxt[s] = '0;
    end
    for (int s = 1; s <= Q_W; s++) begin
      for (int l = 0; l < LANES; l++) begin
        t = {rem_r[s-1][l], acc_r[s-1][l][Q_W-1]};
        diff = t - {1'b0, den_r[s-1]};
        if (t >= {1'b0, den_r[s-1]}) begin
          rem_nxt[s][l] = diff[DEN_W-1:0];
          acc_nxt[s][l] = {acc_r[s-1][l][Q_W-2:0], 1'b1};
        end else begin
          rem_nxt[s][l] = t[DEN_W-1:0];
          acc_nxt[s][l] = {acc_r[s-1][l][Q_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Q_W-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0]  <= den;
      side_r[0] <= side_in;
      for (int l = 0; l < LANES; l++) begin
        rem_r[0][l] <= DEN_W'(num[l] >> Q_W);
        acc_r[0][l] <= num[l][Q_W-1:0];
      end
      for (int s = 1; s <= Q_W; s++) begin
        den_r[s]  <= den_r[s-1];
        side_r[s] <= side_r[s-1];
        rem_r[s]  <= rem_nxt[s];
        acc_r[s]  <= acc_nxt[s];
      end
    end
  end

  assign out_vld  = vld_r[Q_W];
  assign quot     = acc_r[Q_W];
  assign side_out = side_r[Q_W];

endmodule

// File: hw/rtl/diff_drive_wheel_command_unit.sv
// Differential drive wheel command unit: motion command to per-wheel step rates, ramps and counts.
// The depth from an input transfer to its result on the output register does not change with
// FRAC_BITS; most of it lies in three bit-serial divider pipelines in series.
// Throughput: one command per cycle; the whole pipeline holds while a result waits stalled.
// Reset (synchronous, rst_n low) empties the pipeline and sets all three registers to 1.0.
module diff_drive_wheel_command_unit #(
  parameter int FRAC_BITS = ddwc_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  ddwc_pkg::cmd_t                   in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output ddwc_pkg::result_t                out_data,
  input  logic                             cfg_we,
  input  logic [ddwc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ddwc_pkg::CFG_W-1:0]       cfg_wdata
);

  // Width plan. The turn term pi*turn*base fits DW bits, a wheel speed magnitude WW bits.
  localparam int DW     = 64 - FRAC_BITS;
  localparam int WW     = DW + 1;
  localparam int SW     = WW + 1;
  localparam int PH_W   = WW - 1;
  localparam int LIM_NW = WW + 31;
  localparam int PW     = 32 + WW;
  localparam int NW     = PW + 31;
  localparam int NC     = (PW + 31) / 32;
  localparam int PADW   = NC * 32;
  localparam int QW     = 32 + 2 * FRAC_BITS;

  typedef struct packed {
    logic        v_neg;
    logic [31:0] v_mag;
    logic        a_neg;
    logic [31:0] a_mag;
    logic        d_neg;
    logic [31:0] d_mag;
  } mag_t;

  typedef struct packed {
    logic          r_neg;
    logic [WW-1:0] r_mag;
    logic          l_neg;
    logic [WW-1:0] l_mag;
  } pair_t;

  // Carried through the limiter dividers: trig says this limiter fires, lim the flag so far.
  typedef struct packed {
    mag_t  cmd;
    pair_t w;
    logic  trig;
    logic  lim;
  } lim_side_t;

  // Carried through the final divider; lanes are right ramp, left ramp, right steps, left steps.
  typedef struct packed {
    logic [31:0]      v_mag;
    logic [1:0][31:0] rate;
    logic [3:0]       neg;
    logic [3:0]       ovf;
    logic             lim;
    logic             zero;
  } fin_side_t;

  localparam int LS_W = $bits(lim_side_t);
  localparam int FS_W = $bits(fin_side_t);

  // ---------------------------------------------------------------------------------------
  // Configuration registers. Writes must arrive only while the pipeline is empty (not enforced).
  // ---------------------------------------------------------------------------------------
  logic [ddwc_pkg::CFG_W-1:0] wheel_base_r;
  logic [ddwc_pkg::CFG_W-1:0] max_speed_r;
  logic [ddwc_pkg::CFG_W-1:0] spd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_base_r <= ddwc_pkg::CFG_RESET;
      max_speed_r  <= ddwc_pkg::CFG_RESET;
      spd_r        <= ddwc_pkg::CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ddwc_pkg::CFG_WHEEL_BASE:     wheel_base_r <= cfg_wdata;
        ddwc_pkg::CFG_MAX_SPEED:      max_speed_r  <= cfg_wdata;
        ddwc_pkg::CFG_STEPS_PER_DIST: spd_r        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------
  // Flow control. Every stage moves together; the pipeline only holds when the output
  // register has a result that the consumer is stalling. Bubbles move like items, so a
  // transfer is taken in every cycle in which the output side is not stalled.
  // ---------------------------------------------------------------------------------------
  logic adv;
  logic out_vld_r;

  assign adv      = !(out_vld_r && out_stall);
  assign in_stall = !adv;

  logic [8:1]   va_r;
  logic [11:9]  vb_r;
  logic [17:12] vc_r;
  logic         d1_vld;
  logic         d2_vld;
  logic         d3_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r      <= '0;
      vb_r      <= '0;
      vc_r      <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      va_r      <= {va_r[7:1], in_valid};
      vb_r      <= {vb_r[10:9], d1_vld};
      vc_r      <= {vc_r[16:12], d2_vld};
      out_vld_r <= d3_vld;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stages 1 to 5: split fields into sign and magnitude, form the turn term
  // d = trunc(pi * turn * base / 2^FRAC_BITS), then the raw wheel speeds v + d and v - d.
  // ---------------------------------------------------------------------------------------
  mag_t             s1_cmd_r, s2_cmd_r, s3_cmd_r, s4_cmd_r, s5_cmd_r;
  logic             s1_t_neg_r, s2_t_neg_r, s3_t_neg_r, s4_t_neg_r;
  logic [31:0]      s1_t_mag_r;
  logic [62:0]      s2_tw_r;
  logic [63:0]      s3_lo_r;
  logic [62:0]      s3_hi_r;
  logic [DW-1:0]    s4_dm_r;
  logic [WW:0]      s5_vr_r, s5_vl_r;

  mag_t             s1_cmd_nxt;
  logic [94:0]      s4_full;
  logic [DW-1:0]    s4_dm_nxt;
  logic [WW:0]      s5_sv, s5_sd;

  always_comb begin
    s1_cmd_nxt.v_neg = in_data.fwd_speed[31];
    s1_cmd_nxt.v_mag = ddwc_pkg::mag32(in_data.fwd_speed);
    s1_cmd_nxt.a_neg = in_data.fwd_accel[31];
    s1_cmd_nxt.a_mag = ddwc_pkg::mag32(in_data.fwd_accel);
    s1_cmd_nxt.d_neg = in_data.travel[31];
    s1_cmd_nxt.d_mag = ddwc_pkg::mag32(in_data.travel);
    s4_full   = (95'(s3_hi_r) << 32) + 95'(s3_lo_r);
    s4_dm_nxt = DW'(s4_full >> (FRAC_BITS + ddwc_pkg::PI_FRAC));
    s5_sv = SW'(s4_cmd_r.v_mag);
    if (s4_cmd_r.v_neg) begin
      s5_sv = -s5_sv;
    end
    s5_sd = SW'(s4_dm_r);
    if (s4_t_neg_r) begin
      s5_sd = -s5_sd;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd_r   <= s1_cmd_nxt;
      s1_t_neg_r <= in_data.turn_rate[31];
      s1_t_mag_r <= ddwc_pkg::mag32(in_data.turn_rate);
      s2_cmd_r   <= s1_cmd_r;
      s2_t_neg_r <= s1_t_neg_r;
      s2_tw_r    <= 63'(s1_t_mag_r) * 63'(wheel_base_r);
      s3_cmd_r   <= s2_cmd_r;
      s3_t_neg_r <= s2_t_neg_r;
      s3_lo_r    <= 64'(s2_tw_r[31:0]) * 64'(ddwc_pkg::PI_Q30);
      s3_hi_r    <= 63'(s2_tw_r[62:32]) * 63'(ddwc_pkg::PI_Q30);
      s4_cmd_r   <= s3_cmd_r;
      s4_t_neg_r <= s3_t_neg_r;
      s4_dm_r    <= s4_dm_nxt;
      s5_cmd_r   <= s4_cmd_r;
      s5_vr_r    <= s5_sv + s5_sd;
      s5_vl_r    <= s5_sv - s5_sd;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stages 6 to 8 and the first divider: right wheel limiter. When |right| exceeds the
  // limit, right becomes the limit and left becomes |left| * limit / |right|.
  // ---------------------------------------------------------------------------------------
  mag_t              s6_cmd_r, s7_cmd_r;
  pair_t             s6_w_r, s7_w_r;
  logic              s6_trig_r, s7_trig_r;
  logic [62:0]       s7_pl_r;
  logic [PH_W-1:0]   s7_ph_r;
  logic [LIM_NW-1:0] s8_num_r;
  lim_side_t         s8_side_r;

  pair_t             s6_w_nxt;
  lim_side_t         s8_side_nxt;
  logic [WW-1:0]     d1_q;
  logic [LS_W-1:0]   d1_side;

  always_comb begin
    s6_w_nxt.r_neg = s5_vr_r[WW];
    s6_w_nxt.r_mag = WW'(s5_vr_r[WW] ? -s5_vr_r : s5_vr_r);
    s6_w_nxt.l_neg = s5_vl_r[WW];
    s6_w_nxt.l_mag = WW'(s5_vl_r[WW] ? -s5_vl_r : s5_vl_r);
    s8_side_nxt.cmd  = s7_cmd_r;
    s8_side_nxt.w    = s7_w_r;
    s8_side_nxt.trig = s7_trig_r;
    s8_side_nxt.lim  = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_cmd_r  <= s5_cmd_r;
      s6_w_r    <= s6_w_nxt;
      s6_trig_r <= s6_w_nxt.r_mag > WW'(max_speed_r);
      s7_cmd_r  <= s6_cmd_r;
      s7_w_r    <= s6_w_r;
      s7_trig_r <= s6_trig_r;
      s7_pl_r   <= 63'(s6_w_r.l_mag[31:0]) * 63'(max_speed_r);
      s7_ph_r   <= PH_W'(s6_w_r.l_mag[WW-1:32]) * PH_W'(max_speed_r);
      s8_num_r  <= (LIM_NW'(s7_ph_r) << 32) + LIM_NW'(s7_pl_r);
      s8_side_r <= s8_side_nxt;
    end
  end

  ddwc_divider #(
    .NUM_W (LIM_NW),
    .DEN_W (WW),
    .Q_W   (WW),
    .LANES (1),
    .SIDE_W(LS_W)
  ) u_lim_right (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (va_r[8]),
    .num     (s8_num_r),
    .den     (s8_side_r.w.r_mag),
    .side_in (s8_side_r),
    .out_vld (d1_vld),
    .quot    (d1_q),
    .side_out(d1_side)
  );

  // ---------------------------------------------------------------------------------------
  // Stages 9 to 11 and the second divider: apply the right limiter, then run the same check
  // on the (possibly scaled) left speed.
  // ---------------------------------------------------------------------------------------
  lim_side_t         s9_side_r, s10_side_r, s11_side_r;
  logic [62:0]       s10_pl_r;
  logic [PH_W-1:0]   s10_ph_r;
  logic [LIM_NW-1:0] s11_num_r;

  lim_side_t         d1_s;
  lim_side_t         s9_side_nxt;
  logic [WW-1:0]     d2_q;
  logic [LS_W-1:0]   d2_side;

  always_comb begin
    d1_s = lim_side_t'(d1_side);
    s9_side_nxt.cmd = d1_s.cmd;
    s9_side_nxt.w   = d1_s.w;
    if (d1_s.trig) begin
      s9_side_nxt.w.r_mag = WW'(max_speed_r);
      s9_side_nxt.w.l_mag = d1_q;
    end
    s9_side_nxt.lim  = d1_s.trig;
    s9_side_nxt.trig = s9_side_nxt.w.l_mag > WW'(max_speed_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_side_r  <= s9_side_nxt;
      s10_side_r <= s9_side_r;
      s10_pl_r   <= 63'(s9_side_r.w.r_mag[31:0]) * 63'(max_speed_r);
      s10_ph_r   <= PH_W'(s9_side_r.w.r_mag[WW-1:32]) * PH_W'(max_speed_r);
      s11_side_r <= s10_side_r;
      s11_num_r  <= (LIM_NW'(s10_ph_r) << 32) + LIM_NW'(s10_pl_r);
    end
  end

  ddwc_divider #(
    .NUM_W (LIM_NW),
    .DEN_W (WW),
    .Q_W   (WW),
    .LANES (1),
    .SIDE_W(LS_W)
  ) u_lim_left (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (vb_r[11]),
    .num     (s11_num_r),
    .den     (s11_side_r.w.l_mag),
    .side_in (s11_side_r),
    .out_vld (d2_vld),
    .quot    (d2_q),
    .side_out(d2_side)
  );

  // ---------------------------------------------------------------------------------------
  // Stages 12 to 17: apply the left limiter, then per wheel the step rate w * spd >> F and
  // the numerators accel * w * spd and travel * w * spd for the division by |v|. Each wide
  // product is built from 32-bit partial products, registered, then summed.
  // ---------------------------------------------------------------------------------------
  mag_t                       s12_cmd_r, s13_cmd_r, s14_cmd_r, s15_cmd_r, s16_cmd_r;
  pair_t                      s12_w_r, s13_w_r, s14_w_r, s15_w_r, s16_w_r;
  logic                       s12_lim_r, s13_lim_r, s14_lim_r, s15_lim_r, s16_lim_r;
  logic [1:0][62:0]           s13_rs_lo_r;
  logic [1:0][PH_W-1:0]       s13_rs_hi_r;
  logic [1:0][63:0]           s13_pa_lo_r, s13_pd_lo_r;
  logic [1:0][WW-1:0]         s13_pa_hi_r, s13_pd_hi_r;
  logic [1:0][LIM_NW-1:0]     s14_rf_r;
  logic [3:0][PW-1:0]         s14_p_r;
  logic [1:0][31:0]           s15_rate_r, s16_rate_r;
  logic [3:0][NC-1:0][62:0]   s15_cp_r;
  logic [3:0][NW-1:0]         s16_x_r, s17_x_r;
  fin_side_t                  s17_side_r;

  lim_side_t                  d2_s;
  pair_t                      s12_w_nxt;
  logic [1:0][WW-1:0]         s13_wm;
  logic [1:0]                 s15_wneg;
  logic [LIM_NW-1:0]          s15_sh;
  logic [1:0][31:0]           s15_rate_nxt;
  logic [PADW-1:0]            s15_pp;
  logic [3:0][NC-1:0][62:0]   s15_cp_nxt;
  logic [3:0][NW-1:0]         s16_x_nxt;
  fin_side_t                  s17_side_nxt;

  always_comb begin
    d2_s = lim_side_t'(d2_side);
    s12_w_nxt = d2_s.w;
    if (d2_s.trig) begin
      s12_w_nxt.l_mag = WW'(max_speed_r);
      s12_w_nxt.r_mag = d2_q;
    end
    s13_wm[0] = s12_w_r.r_mag;
    s13_wm[1] = s12_w_r.l_mag;
    s15_wneg  = {s14_w_r.l_neg, s14_w_r.r_neg};
    s15_sh    = '0;
    s15_pp    = '0;
    for (int k = 0; k < 2; k++) begin
      s15_sh = LIM_NW'(s14_rf_r[k] >> FRAC_BITS);
      s15_rate_nxt[k] = ddwc_pkg::sat32(|s15_sh[LIM_NW-1:32], s15_sh[31:0], s15_wneg[k]);
    end
    for (int j = 0; j < 4; j++) begin
      s15_pp = PADW'(s14_p_r[j]);
      for (int c = 0; c < NC; c++) begin
        s15_cp_nxt[j][c] = 63'(s15_pp[32*c +: 32]) * 63'(spd_r);
      end
    end
    for (int j = 0; j < 4; j++) begin
      s16_x_nxt[j] = '0;
      for (int c = 0; c < NC; c++) begin
        s16_x_nxt[j] = s16_x_nxt[j] + (NW'(s15_cp_r[j][c]) << (32 * c));
      end
    end
    s17_side_nxt.v_mag  = s16_cmd_r.v_mag;
    s17_side_nxt.rate   = s16_rate_r;
    s17_side_nxt.neg[0] = s16_cmd_r.a_neg ^ s16_w_r.r_neg ^ s16_cmd_r.v_neg;
    s17_side_nxt.neg[1] = s16_cmd_r.a_neg ^ s16_w_r.l_neg ^ s16_cmd_r.v_neg;
    s17_side_nxt.neg[2] = s16_cmd_r.d_neg ^ s16_w_r.r_neg ^ s16_cmd_r.v_neg;
    s17_side_nxt.neg[3] = s16_cmd_r.d_neg ^ s16_w_r.l_neg ^ s16_cmd_r.v_neg;
    // A quotient that needs more than QW bits saturates whatever its low bits are.
    for (int j = 0; j < 4; j++) begin
      s17_side_nxt.ovf[j] = NW'(s16_x_r[j] >> QW) >= NW'(s16_cmd_r.v_mag);
    end
    s17_side_nxt.lim  = s16_lim_r;
    s17_side_nxt.zero = (s16_cmd_r.v_mag == 32'd0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s12_cmd_r <= d2_s.cmd;
      s12_w_r   <= s12_w_nxt;
      s12_lim_r <= d2_s.lim | d2_s.trig;
      s13_cmd_r <= s12_cmd_r;
      s13_w_r   <= s12_w_r;
      s13_lim_r <= s12_lim_r;
      for (int k = 0; k < 2; k++) begin
        s13_rs_lo_r[k] <= 63'(s13_wm[k][31:0]) * 63'(spd_r);
        s13_rs_hi_r[k] <= PH_W'(s13_wm[k][WW-1:32]) * PH_W'(spd_r);
        s13_pa_lo_r[k] <= 64'(s12_cmd_r.a_mag) * 64'(s13_wm[k][31:0]);
        s13_pa_hi_r[k] <= WW'(s12_cmd_r.a_mag) * WW'(s13_wm[k][WW-1:32]);
        s13_pd_lo_r[k] <= 64'(s12_cmd_r.d_mag) * 64'(s13_wm[k][31:0]);
        s13_pd_hi_r[k] <= WW'(s12_cmd_r.d_mag) * WW'(s13_wm[k][WW-1:32]);
      end
      s14_cmd_r <= s13_cmd_r;
      s14_w_r   <= s13_w_r;
      s14_lim_r <= s13_lim_r;
      for (int k = 0; k < 2; k++) begin
        s14_rf_r[k]  <= (LIM_NW'(s13_rs_hi_r[k]) << 32) + LIM_NW'(s13_rs_lo_r[k]);
        s14_p_r[k]   <= (PW'(s13_pa_hi_r[k]) << 32) + PW'(s13_pa_lo_r[k]);
        s14_p_r[k+2] <= (PW'(s13_pd_hi_r[k]) << 32) + PW'(s13_pd_lo_r[k]);
      end
      s15_cmd_r  <= s14_cmd_r;
      s15_w_r    <= s14_w_r;
      s15_lim_r  <= s14_lim_r;
      s15_rate_r <= s15_rate_nxt;
      s15_cp_r   <= s15_cp_nxt;
      s16_cmd_r  <= s15_cmd_r;
      s16_w_r    <= s15_w_r;
      s16_lim_r  <= s15_lim_r;
      s16_rate_r <= s15_rate_r;
      s16_x_r    <= s16_x_nxt;
      s17_x_r    <= s16_x_r;
      s17_side_r <= s17_side_nxt;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Final divider: the four numerators share the divisor |v|. QW quotient bits cover both
  // the ramp (shifted by FRAC_BITS) and the step count (shifted by 2 * FRAC_BITS).
  // ---------------------------------------------------------------------------------------
  logic [3:0][QW-1:0]  d3_q;
  logic [FS_W-1:0]     d3_side;

  ddwc_divider #(
    .NUM_W (NW),
    .DEN_W (32),
    .Q_W   (QW),
    .LANES (4),
    .SIDE_W(FS_W)
  ) u_wheel_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (vc_r[17]),
    .num     (s17_x_r),
    .den     (s17_side_r.v_mag),
    .side_in (s17_side_r),
    .out_vld (d3_vld),
    .quot    (d3_q),
    .side_out(d3_side)
  );

  // ---------------------------------------------------------------------------------------
  // Output register: saturate ramps and step counts, zero them for a zero forward speed.
  // ---------------------------------------------------------------------------------------
  fin_side_t          d3_s;
  ddwc_pkg::result_t  out_data_r;
  ddwc_pkg::result_t  out_data_nxt;
  logic [1:0][31:0]   ramp;
  logic [1:0][31:0]   steps;

  always_comb begin
    d3_s = fin_side_t'(d3_side);
    for (int k = 0; k < 2; k++) begin
      ramp[k] = ddwc_pkg::sat32(d3_s.ovf[k] | (|d3_q[k][QW-1:32+FRAC_BITS]),
                                d3_q[k][FRAC_BITS+31:FRAC_BITS], d3_s.neg[k]);
      steps[k] = ddwc_pkg::sat32(d3_s.ovf[k+2], d3_q[k+2][QW-1:2*FRAC_BITS],
                                 d3_s.neg[k+2]);
      if (d3_s.zero) begin
        ramp[k]  = '0;
        steps[k] = '0;
      end
    end
    out_data_nxt.right_rate    = d3_s.rate[0];
    out_data_nxt.left_rate     = d3_s.rate[1];
    out_data_nxt.right_ramp    = ramp[0];
    out_data_nxt.left_ramp     = ramp[1];
    out_data_nxt.right_steps   = steps[0];
    out_data_nxt.left_steps    = steps[1];
    out_data_nxt.speed_limited = d3_s.lim;
    out_data_nxt.zero_speed    = d3_s.zero;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_zero_speed_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_speed |->
      out_data.right_ramp == 32'sd0 && out_data.left_ramp == 32'sd0 &&
      out_data.right_steps == 32'sd0 && out_data.left_steps == 32'sd0)
    else $error("zero forward speed left a nonzero ramp or step count");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while the result register is stalled");
  a_flow_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled although the output side is free");
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule
